### hw/rtl/amp_ptt_sequencer_interlock_defines.svh
// Assertion macros shared by the amplifier PTT sequencer RTL.
`ifndef AMP_PTT_SEQUENCER_INTERLOCK_DEFINES_SVH
`define AMP_PTT_SEQUENCER_INTERLOCK_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define APSI_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define APSI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/apsi_pkg.sv
// Types, codes and helpers for the amplifier PTT sequencer with interlock.
package apsi_pkg;

  localparam int DelayBits  = 16;
  localparam int OffDelayW  = 16;
  localparam int LevelW     = 10;
  localparam int TempW      = 10;
  localparam int CodeW      = 8;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 2;
  localparam int TempCmpW   = TempW + 2;

  localparam logic [CfgIdxW-1:0] CfgOffDelay = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFanOn    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgFanOff   = CfgIdxW'(2);

  localparam logic [OffDelayW-1:0] OffDelayReset = OffDelayW'(500);
  localparam logic [LevelW-1:0]    FanOnReset    = LevelW'(200);
  localparam logic [LevelW-1:0]    FanOffReset   = LevelW'(180);

  localparam logic signed [TempCmpW-1:0] TempBOffset = TempCmpW'(10);

  localparam logic [1:0] ModeStandby = 2'd0;
  localparam logic [1:0] ModeOperate = 2'd1;
  localparam logic [1:0] ModeFault   = 2'd2;

  localparam logic [2:0] StepIdle     = 3'd0;
  localparam logic [2:0] StepWaitSw1  = 3'd1;
  localparam logic [2:0] StepWaitSw2  = 3'd2;
  localparam logic [2:0] StepOnAir    = 3'd3;
  localparam logic [2:0] StepOffDelay = 3'd4;
  localparam logic [2:0] StepSw2Clear = 3'd5;
  localparam logic [2:0] StepAbort    = 3'd6;

  typedef struct packed {
    logic              operate_n;
    logic              ptt_n;
    logic              interlock_n;
    logic              fault_reset_n;
    logic              switch1_ready;
    logic              switch2_ready;
    logic [CodeW-1:0]  interlock_code;
    logic [TempW-1:0]  temp_a;
    logic [TempW-1:0]  temp_b;
  } in_item_t;

  typedef struct packed {
    logic              supply_enable;
    logic              switch1_enable;
    logic              switch2_enable;
    logic              gate_enable;
    logic              on_air;
    logic              fault_active;
    logic [CodeW-1:0]  fault_leds;
    logic              fan_on;
    logic [1:0]        mode_code;
  } out_item_t;

  typedef struct packed {
    logic [OffDelayW-1:0] off_delay_ticks;
    logic [LevelW-1:0]    fan_on_level;
    logic [LevelW-1:0]    fan_off_level;
  } cfg_t;

  // Clamp the programmed off delay to what the counter can hold.
  function automatic logic [DelayBits-1:0] delay_load(logic [OffDelayW-1:0] ticks);
    logic [OffDelayW+DelayBits-1:0] wide;
    logic [OffDelayW+DelayBits-1:0] lim;
    wide = (OffDelayW+DelayBits)'(ticks);
    lim  = (OffDelayW+DelayBits)'({DelayBits{1'b1}});
    if (wide > lim) begin
      delay_load = '1;
    end else begin
      delay_load = wide[DelayBits-1:0];
    end
  endfunction

endpackage

### hw/rtl/apsi_fan.sv
// Fan drive with hysteresis over two temperature samples.
module apsi_fan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [apsi_pkg::TempW-1:0] temp_a_i,
  input  logic [apsi_pkg::TempW-1:0] temp_b_i,
  input  apsi_pkg::cfg_t             cfg_i,
  output logic                       fan_d_o
);
  import apsi_pkg::*;

  logic fan_q;
  logic fan_d;
  logic signed [TempCmpW-1:0] ta;
  logic signed [TempCmpW-1:0] tb;
  logic signed [TempCmpW-1:0] on_lvl;
  logic signed [TempCmpW-1:0] off_lvl;

  function automatic logic fan_apply(logic cur, logic signed [TempCmpW-1:0] v,
                                     logic signed [TempCmpW-1:0] on_l,
                                     logic signed [TempCmpW-1:0] off_l);
    logic f;
    f = cur;
    if (v > on_l && !f) f = 1'b1;
    if (v < off_l && f) f = 1'b0;
    return f;
  endfunction

  always_comb begin
    ta      = $signed({2'b00, temp_a_i});
    // sensor 1 reads high by the offset; may go negative
    tb      = $signed({2'b00, temp_b_i}) - TempBOffset;
    on_lvl  = $signed({2'b00, cfg_i.fan_on_level});
    off_lvl = $signed({2'b00, cfg_i.fan_off_level});
    fan_d   = fan_apply(fan_apply(fan_q, ta, on_lvl, off_lvl), tb, on_lvl, off_lvl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q <= 1'b0;
    end else if (step_i) begin
      fan_q <= fan_d;
    end
  end

  assign fan_d_o = fan_d;

endmodule

### hw/rtl/apsi_core.sv
// Mode, fault latch and transmit sequencer state with its next-state logic.
`include "amp_ptt_sequencer_interlock_defines.svh"

module apsi_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  apsi_pkg::in_item_t  item_i,
  input  apsi_pkg::cfg_t      cfg_i,
  output apsi_pkg::out_item_t result_o
);
  import apsi_pkg::*;

  logic [1:0]           mode_q, mode_d;
  logic [2:0]           seq_q, seq_d;
  logic [DelayBits-1:0] count_q, count_d;
  logic [CodeW-1:0]     fault_code_q, fault_code_d;
  logic                 prev_ilk_q;
  logic                 prev_ptt_q;
  logic [1:0]           sel_mode;
  logic                 fault;
  logic                 tx_ok;
  logic [DelayBits-1:0] load;
  logic [DelayBits-1:0] count_dec;
  logic                 fan_d;

  apsi_fan u_fan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step_i),
    .temp_a_i (item_i.temp_a),
    .temp_b_i (item_i.temp_b),
    .cfg_i    (cfg_i),
    .fan_d_o  (fan_d)
  );

  always_comb begin
    sel_mode     = item_i.operate_n ? ModeStandby : ModeOperate;
    mode_d       = mode_q;
    fault_code_d = fault_code_q;
    if (mode_q == ModeFault) begin
      if (item_i.interlock_n && !item_i.fault_reset_n) mode_d = sel_mode;
    end else if (prev_ilk_q && !item_i.interlock_n) begin
      mode_d       = ModeFault;
      fault_code_d = item_i.interlock_code;
    end else begin
      mode_d = sel_mode;
    end
    fault = (mode_d == ModeFault);
    tx_ok = (mode_d == ModeOperate) && !item_i.ptt_n;

    load      = delay_load(cfg_i.off_delay_ticks);
    count_dec = count_q - DelayBits'(1);
    seq_d     = seq_q;
    count_d   = count_q;
    case (seq_q)
      StepWaitSw1: begin
        if (!tx_ok) seq_d = StepAbort;
        else if (item_i.switch1_ready) seq_d = StepWaitSw2;
      end
      StepWaitSw2: begin
        if (!tx_ok) seq_d = StepAbort;
        else if (item_i.switch2_ready) seq_d = StepOnAir;
      end
      StepOnAir: begin
        if (fault) begin
          seq_d = StepAbort;
        end else if (!tx_ok) begin
          // zero delay skips straight to the switch 2 release
          if (load == '0) begin
            seq_d = StepSw2Clear;
          end else begin
            count_d = load;
            seq_d   = StepOffDelay;
          end
        end
      end
      StepOffDelay: begin
        if (fault) begin
          seq_d = StepAbort;
        end else begin
          count_d = count_dec;
          if (count_dec == '0) seq_d = StepSw2Clear;
        end
      end
      StepSw2Clear: begin
        if (fault) seq_d = StepAbort;
        else if (!item_i.switch2_ready) seq_d = StepIdle;
      end
      StepAbort: begin
        if (!item_i.switch2_ready) seq_d = StepIdle;
      end
      default: begin
        // key only on a fresh PTT press
        seq_d = (tx_ok && prev_ptt_q) ? StepWaitSw1 : StepIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeStandby;
      seq_q        <= StepIdle;
      count_q      <= '0;
      fault_code_q <= '0;
      prev_ilk_q   <= 1'b1;
      prev_ptt_q   <= 1'b1;
    end else if (step_i) begin
      mode_q       <= mode_d;
      seq_q        <= seq_d;
      count_q      <= count_d;
      fault_code_q <= fault_code_d;
      prev_ilk_q   <= item_i.interlock_n;
      prev_ptt_q   <= item_i.ptt_n;
    end
  end

  always_comb begin
    result_o.supply_enable  = (mode_d == ModeOperate);
    result_o.switch1_enable = (seq_d >= StepWaitSw1) && (seq_d <= StepAbort);
    result_o.switch2_enable = (seq_d >= StepWaitSw2) && (seq_d <= StepOffDelay);
    result_o.gate_enable    = (seq_d == StepOnAir);
    result_o.on_air         = (seq_d >= StepOnAir) && (seq_d <= StepSw2Clear);
    result_o.fault_active   = fault;
    result_o.fault_leds     = ~fault_code_d;
    result_o.fan_on         = fan_d;
    result_o.mode_code      = mode_d;
  end

  `APSI_ASSERT_NOW(a_on_air_in_operate, seq_q == StepOnAir, mode_q == ModeOperate, "on air outside operate mode")
  `APSI_ASSERT_NOW(a_fault_drops_chain, mode_q == ModeFault, seq_q == StepIdle || seq_q == StepAbort, "sequencer live during fault")
  `APSI_ASSERT_NEXT(a_fault_latch, step_i && prev_ilk_q && !item_i.interlock_n && mode_q != ModeFault, mode_q == ModeFault && fault_code_q == $past(item_i.interlock_code), "interlock edge not latched")

endmodule

### hw/rtl/amp_ptt_sequencer_interlock.sv
// Amplifier PTT sequencer with interlock: top level with word pipeline and registers.
//
// One input word is one sample of the amplifier's pins taken on a sequencer tick;
// each accepted word yields exactly one result word showing the state after it.
// Input and result channels use valid/ready. A word accepted on the input lands in
// the input register, is processed and loaded into the result register, and is
// offered on out_valid_o from then on. Throughput is one word per cycle while the
// receiver keeps taking results; the only loop is the state update between the
// input register and the result register.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more; in_ready_o falls only when both are full.
// Reset clears the pipeline, puts the block in standby with the sequencer idle,
// all switches off, fan off, and loads the registers with their defaults
// (off delay 500 ticks, fan on level 200, fan off level 180).
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i with no wait;
// the user must write them only while no word is in flight (not enforced by the block).
`include "amp_ptt_sequencer_interlock_defines.svh"

module amp_ptt_sequencer_interlock (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  apsi_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output apsi_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [apsi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apsi_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import apsi_pkg::*;

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  out_item_t result;
  logic      advance;
  logic      step;

  // advance the input register whenever the result register can take a word
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_delay_ticks <= OffDelayReset;
      cfg_q.fan_on_level    <= FanOnReset;
      cfg_q.fan_off_level   <= FanOffReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOffDelay: cfg_q.off_delay_ticks <= cfg_wdata_i[OffDelayW-1:0];
        CfgFanOn:    cfg_q.fan_on_level    <= cfg_wdata_i[LevelW-1:0];
        CfgFanOff:   cfg_q.fan_off_level   <= cfg_wdata_i[LevelW-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance)    out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_data_q <= in_data_i;
    if (step)                     out_data_q <= result;
  end

  apsi_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_data_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `APSI_ASSERT_NOW(a_ready_only_when_full, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled without full pipeline")

endmodule

### test/amp_ptt_sequencer_interlock_tb.sv
// Testbench for the amplifier PTT sequencer with interlock: random pin words against a predictor.
module amp_ptt_sequencer_interlock_tb;
  import apsi_pkg::*;

  localparam int LongStall = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgOffDelay;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  amp_ptt_sequencer_interlock u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers and the block state
  logic [OffDelayW-1:0] off_delay_cfg = OffDelayReset;
  logic [LevelW-1:0]    fan_on_cfg    = FanOnReset;
  logic [LevelW-1:0]    fan_off_cfg   = FanOffReset;

  logic [1:0]           mode_q       = ModeStandby;
  logic [2:0]           step_q       = StepIdle;
  logic [DelayBits-1:0] delay_left   = '0;
  logic [CodeW-1:0]     latched_code = '0;
  logic                 ilk_last     = 1'b1;
  logic                 ptt_last     = 1'b1;
  logic                 fan_q        = 1'b0;

  in_item_t  pending_samples[$];
  out_item_t expected_status[$];

  int send_idle_pct = 19;
  int recv_idle_pct = 75;
  int noise_pct     = 0;
  int queued        = 0;
  int error_count   = 0;
  bit stall_armed   = 1'b0;
  int stall_count   = 0;

  function automatic void fan_follow(logic signed [TempCmpW-1:0] v);
    if (v > signed'({2'b00, fan_on_cfg}) && !fan_q) fan_q = 1'b1;
    if (v < signed'({2'b00, fan_off_cfg}) && fan_q) fan_q = 1'b0;
  endfunction

  // Advance the predicted state by one pin word and return the status it shows
  function automatic out_item_t next_status(in_item_t s);
    out_item_t            r;
    logic [1:0]           sel;
    logic                 faulted;
    logic                 tx_ok;
    logic [DelayBits-1:0] load;
    sel = s.operate_n ? ModeStandby : ModeOperate;
    if (mode_q == ModeFault) begin
      if (s.interlock_n && !s.fault_reset_n) mode_q = sel;
    end else if (ilk_last && !s.interlock_n) begin
      mode_q = ModeFault;
      latched_code = s.interlock_code;
    end else begin
      mode_q = sel;
    end
    faulted = (mode_q == ModeFault);
    tx_ok = (mode_q == ModeOperate) && !s.ptt_n;

    case (step_q)
      StepWaitSw1: begin
        if (!tx_ok) step_q = StepAbort;
        else if (s.switch1_ready) step_q = StepWaitSw2;
      end
      StepWaitSw2: begin
        if (!tx_ok) step_q = StepAbort;
        else if (s.switch2_ready) step_q = StepOnAir;
      end
      StepOnAir: begin
        if (faulted) begin
          step_q = StepAbort;
        end else if (!tx_ok) begin
          // saturate when the counter is narrower than the register
          if (off_delay_cfg > {DelayBits{1'b1}}) load = '1;
          else load = DelayBits'(off_delay_cfg);
          if (load == '0) begin
            step_q = StepSw2Clear;
          end else begin
            delay_left = load;
            step_q = StepOffDelay;
          end
        end
      end
      StepOffDelay: begin
        if (faulted) begin
          step_q = StepAbort;
        end else begin
          delay_left = delay_left - 1'b1;
          if (delay_left == '0) step_q = StepSw2Clear;
        end
      end
      StepSw2Clear: begin
        if (faulted) step_q = StepAbort;
        else if (!s.switch2_ready) step_q = StepIdle;
      end
      StepAbort: begin
        if (!s.switch2_ready) step_q = StepIdle;
      end
      default: begin
        step_q = (tx_ok && ptt_last) ? StepWaitSw1 : StepIdle;
      end
    endcase

    // sensor 0 first, then sensor 1 less its offset
    fan_follow(signed'({2'b00, s.temp_a}));
    fan_follow(signed'({2'b00, s.temp_b}) - TempBOffset);

    ilk_last = s.interlock_n;
    ptt_last = s.ptt_n;

    r.supply_enable  = (mode_q == ModeOperate);
    r.switch1_enable = (step_q >= StepWaitSw1) && (step_q <= StepAbort);
    r.switch2_enable = (step_q >= StepWaitSw2) && (step_q <= StepOffDelay);
    r.gate_enable    = (step_q == StepOnAir);
    r.on_air         = (step_q >= StepOnAir) && (step_q <= StepSw2Clear);
    r.fault_active   = faulted;
    r.fault_leds     = ~latched_code;
    r.fan_on         = fan_q;
    r.mode_code      = mode_q;
    return r;
  endfunction

  function automatic in_item_t mk(logic op_n, logic ptt_n, logic ilk_n, logic rst_n,
                                  logic sw1, logic sw2, logic [CodeW-1:0] code,
                                  logic [TempW-1:0] ta, logic [TempW-1:0] tb);
    in_item_t s;
    s.operate_n      = op_n;
    s.ptt_n          = ptt_n;
    s.interlock_n    = ilk_n;
    s.fault_reset_n  = rst_n;
    s.switch1_ready  = sw1;
    s.switch2_ready  = sw2;
    s.interlock_code = code;
    s.temp_a         = ta;
    s.temp_b         = tb;
    return s;
  endfunction

  // Random pin level
  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  // Temperatures: full range, near either level, or low enough to go negative
  function automatic logic [TempW-1:0] pick_temp(bit is_b);
    int v;
    int shift;
    shift = is_b ? 10 : 0;
    case ($urandom_range(3))
      0: v = $urandom_range(1023);
      1: v = int'(fan_on_cfg) + shift + int'($urandom_range(6)) - 3;
      2: v = int'(fan_off_cfg) + shift + int'($urandom_range(6)) - 3;
      default: v = $urandom_range(15);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return TempW'(v);
  endfunction

  function automatic in_item_t ctl(logic op_n, logic ptt_n, logic ilk_n, logic rst_n,
                                   logic sw1, logic sw2);
    return mk(op_n, ptt_n, ilk_n, rst_n, sw1, sw2, CodeW'($urandom), pick_temp(1'b0),
              pick_temp(1'b1));
  endfunction

  // Queue a word, now and then with one control pin flipped
  task automatic add_sample(in_item_t s);
    int idx;
    if (int'($urandom_range(99)) < noise_pct) begin
      idx = $bits(in_item_t) - 1 - int'($urandom_range(5));
      s[idx] = ~s[idx];
    end
    pending_samples.push_back(s);
    queued++;
  endtask

  // Press, switch feedback with random lags, hold on air, release and let go
  task automatic queue_keying();
    int  tail;
    logic by_op;
    by_op = ($urandom_range(9) == 0);
    tail = (off_delay_cfg > 40) ? 40 : int'(off_delay_cfg);
    repeat ($urandom_range(1, 3)) add_sample(ctl(0, 1, 1, 1, 0, 0));
    repeat ($urandom_range(0, 4)) add_sample(ctl(0, 0, 1, 1, 0, 0));
    repeat ($urandom_range(0, 4)) add_sample(ctl(0, 0, 1, 1, 1, 0));
    repeat ($urandom_range(1, 6)) add_sample(ctl(0, 0, 1, 1, 1, 1));
    repeat (tail + int'($urandom_range(1, 3)))
      add_sample(ctl(by_op, !by_op, 1, 1, 1, 1));
    repeat ($urandom_range(1, 3)) add_sample(ctl(by_op, 1, 1, 1, 1, 0));
    add_sample(ctl(by_op, 1, 1, 1, 0, 0));
  endtask

  task automatic queue_fault();
    repeat ($urandom_range(0, 2))
      add_sample(ctl(coin(), coin(), 1, 1, coin(), coin()));
    repeat ($urandom_range(1, 4))
      add_sample(ctl(coin(), coin(), 0, coin(), coin(), coin()));
    repeat ($urandom_range(0, 2))
      add_sample(ctl(coin(), coin(), coin(), 1, coin(), 0));
    repeat ($urandom_range(1, 2)) add_sample(ctl(coin(), 1, 1, 0, 0, 0));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CfgOffDelay: off_delay_cfg = data[OffDelayW-1:0];
      CfgFanOn:    fan_on_cfg    = data[LevelW-1:0];
      CfgFanOff:   fan_off_cfg   = data[LevelW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Look between edges so that the driver and monitor have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Driver: offer queued words; predict each one as it is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) expected_status.push_back(next_status(in_data));
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("supply_enable", want.supply_enable, out_data.supply_enable);
          check_field("switch1_enable", want.switch1_enable, out_data.switch1_enable);
          check_field("switch2_enable", want.switch2_enable, out_data.switch2_enable);
          check_field("gate_enable", want.gate_enable, out_data.gate_enable);
          check_field("on_air", want.on_air, out_data.on_air);
          check_field("fault_active", want.fault_active, out_data.fault_active);
          check_field("fault_leds", want.fault_leds, out_data.fault_leds);
          check_field("fan_on", want.fan_on, out_data.fan_on);
          check_field("mode_code", want.mode_code, out_data.mode_code);
        end
      end
      // hold off for a long stretch once, so the input backs up
      if (stall_armed && stall_count < LongStall) begin
        stall_count <= stall_count + 1;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          goal;
    int unsigned pick;
    logic [63:0] raw;
    in_item_t    s;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words with the reset settings
    add_sample(mk(1, 1, 0, 1, 0, 0, 8'hA5, 10'd0, 10'd0));       // interlock low from the start
    add_sample(mk(1, 1, 1, 1, 0, 0, 8'h5A, 10'd0, 10'd9));
    add_sample(mk(1, 1, 0, 1, 0, 0, 8'h00, 10'd1023, 10'd1023)); // second edge: keep first code
    add_sample(mk(0, 1, 0, 0, 0, 0, 8'hFF, 10'd201, 10'd210));   // reset while interlock low
    add_sample(mk(0, 1, 1, 0, 0, 0, 8'hFF, 10'd200, 10'd190));   // clear into operate
    add_sample(mk(0, 1, 1, 1, 0, 0, 8'h00, 10'd179, 10'd189));
    add_sample(mk(0, 0, 1, 1, 0, 0, 8'h55, 10'h2AA, 10'h155));
    add_sample(mk(0, 0, 1, 1, 1, 0, 8'hAA, 10'h155, 10'h2AA));
    add_sample(mk(0, 1, 1, 1, 1, 1, 8'h0F, 10'd300, 10'd300));   // release before on air
    add_sample(mk(0, 0, 1, 1, 1, 1, 8'hF0, 10'd300, 10'd300));   // press during abort
    add_sample(mk(0, 0, 1, 1, 1, 0, 8'h3C, 10'd300, 10'd300));
    add_sample(mk(0, 1, 1, 1, 0, 0, 8'hC3, 10'd300, 10'd300));
    add_sample(mk(0, 0, 1, 1, 1, 0, 8'h01, 10'd300, 10'd300));
    add_sample(mk(0, 0, 1, 1, 1, 1, 8'h80, 10'd300, 10'd300));
    add_sample(mk(0, 0, 1, 1, 1, 1, 8'h7E, 10'd300, 10'd300));   // on air
    add_sample(mk(0, 0, 0, 1, 1, 1, 8'hFF, 10'd300, 10'd300));   // interlock while on air
    add_sample(mk(0, 0, 0, 1, 1, 0, 8'h00, 10'd300, 10'd300));
    add_sample(mk(1, 1, 1, 0, 0, 0, 8'h00, 10'd300, 10'd300));   // clear into standby
    add_sample(mk(1, 1, 1, 1, 0, 0, 8'h00, 10'd1023, 10'd0));    // sensor 1 overrides sensor 0
    add_sample(mk(0, 1, 1, 1, 0, 0, 8'h00, 10'd1023, 10'd1023));
    wait_drained();
    noise_pct = 3;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 75;
        recv_idle_pct = 19;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          write_reg(CfgOffDelay, 16'd0);
          write_reg(CfgFanOn, 16'd1023);
          write_reg(CfgFanOff, 16'd0);
        end
        1: begin
          write_reg(CfgOffDelay, 16'd1);
          write_reg(CfgFanOn, 16'd0);
          write_reg(CfgFanOff, 16'd1023);
        end
        2: begin
          write_reg(CfgOffDelay, 16'd3);
          write_reg(CfgFanOn, 16'(FanOnReset));
          write_reg(CfgFanOff, 16'(FanOffReset));
        end
        3: begin
          write_reg(CfgOffDelay, 16'hFFFF);
          write_reg(CfgFanOn, 16'($urandom_range(1023)));
          write_reg(CfgFanOff, 16'($urandom_range(1023)));
        end
        4: begin
          write_reg(CfgOffDelay, 16'd2);
          write_reg(CfgFanOn, 16'd512);
          write_reg(CfgFanOff, 16'd500);
        end
        default: begin
          write_reg(CfgOffDelay, 16'(OffDelayReset));
          write_reg(CfgFanOn, 16'd200);
          write_reg(CfgFanOff, 16'd180);
        end
      endcase

      queued = 0;
      goal = 250;
      while (queued < goal) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          queue_keying();
        end else if (pick < 82) begin
          queue_fault();
        end else if (pick < 92) begin
          repeat ($urandom_range(2, 8))
            add_sample(ctl(coin(), coin(), 1, coin(), coin(), coin()));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            raw = {$urandom, $urandom};
            s = raw[$bits(in_item_t)-1:0];
            add_sample(s);
          end
        end
      end
      if (phase == 4) stall_armed = 1'b1;
      // let every result come home before touching the registers
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### amp_ptt_sequencer_interlock.f
+incdir+hw/rtl
hw/rtl/apsi_pkg.sv
hw/rtl/apsi_fan.sv
hw/rtl/apsi_core.sv
hw/rtl/amp_ptt_sequencer_interlock.sv
test/amp_ptt_sequencer_interlock_tb.sv
